### src/md5_digest_engine_unit_assert.svh
// ----------------------------------------------------------------------------
// MD5 digest engine assertion macros
// Shorthand for the concurrent checks of the digest engine, clocked on clk and
// held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MD5_DIGEST_ENGINE_UNIT_ASSERT_SVH
`define MD5_DIGEST_ENGINE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MDE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MDE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/md5de_pkg.sv
// ----------------------------------------------------------------------------
// MD5 digest engine package
// Microcode format, program, round constants and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package md5de_pkg;

	typedef enum logic [3:0] {
		OP_ACCEPT,
		OP_NONE,
		OP_PAD80,
		OP_ZERO,
		OP_CLRPTR,
		OP_LENLO,
		OP_LENHI,
		OP_EMIT,
		OP_LOAD,
		OP_RA,
		OP_RB,
		OP_ADD
	} op_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_CALL,
		J_RET,
		J_IF,
		J_WAIT,
		J_ACCEPT
	} jmp_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NOTFIN,
		C_NOTEXTRA,
		C_PTR64,
		C_PTR56,
		C_NOTDONE,
		C_LASTBEAT
	} cond_t;

	typedef logic [3:0] pc_t;

	typedef struct packed {
		op_t   op;
		jmp_t  jmp;
		cond_t cond;
		pc_t   target;
	} ucw_t;

	localparam pc_t PC_IDLE   = 4'd0;
	localparam pc_t PC_CHKFIN = 4'd1;
	localparam pc_t PC_PAD    = 4'd2;
	localparam pc_t PC_ZERO64 = 4'd3;
	localparam pc_t PC_FLUSH  = 4'd4;
	localparam pc_t PC_ZERO56 = 4'd5;
	localparam pc_t PC_LENLO  = 4'd6;
	localparam pc_t PC_LENHI  = 4'd7;
	localparam pc_t PC_EMIT   = 4'd8;
	localparam pc_t PC_LOAD   = 4'd9;
	localparam pc_t PC_RA     = 4'd10;
	localparam pc_t PC_RB     = 4'd11;
	localparam pc_t PC_ADD    = 4'd12;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hEFCDAB89;
	localparam logic [31:0] INIT_C = 32'h98BADCFE;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [3:0]  LEN_LO_WORD = 4'd14;
	localparam logic [3:0]  LEN_HI_WORD = 4'd15;

	function automatic ucw_t ucode(input pc_t pc);
		ucw_t w;
		case (pc)
			PC_IDLE:   w = '{OP_ACCEPT, J_ACCEPT, C_ALWAYS,   PC_LOAD};
			PC_CHKFIN: w = '{OP_NONE,   J_IF,     C_NOTFIN,   PC_IDLE};
			PC_PAD:    w = '{OP_PAD80,  J_IF,     C_NOTEXTRA, PC_ZERO56};
			PC_ZERO64: w = '{OP_ZERO,   J_WAIT,   C_PTR64,    PC_FLUSH};
			PC_FLUSH:  w = '{OP_CLRPTR, J_CALL,   C_ALWAYS,   PC_LOAD};
			PC_ZERO56: w = '{OP_ZERO,   J_WAIT,   C_PTR56,    PC_LENLO};
			PC_LENLO:  w = '{OP_LENLO,  J_NEXT,   C_ALWAYS,   PC_IDLE};
			PC_LENHI:  w = '{OP_LENHI,  J_CALL,   C_ALWAYS,   PC_LOAD};
			PC_EMIT:   w = '{OP_EMIT,   J_WAIT,   C_LASTBEAT, PC_IDLE};
			PC_LOAD:   w = '{OP_LOAD,   J_NEXT,   C_ALWAYS,   PC_IDLE};
			PC_RA:     w = '{OP_RA,     J_NEXT,   C_ALWAYS,   PC_IDLE};
			PC_RB:     w = '{OP_RB,     J_IF,     C_NOTDONE,  PC_RA};
			PC_ADD:    w = '{OP_ADD,    J_RET,    C_ALWAYS,   PC_IDLE};
			default:   w = '{OP_NONE,   J_IF,     C_ALWAYS,   PC_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic [31:0] round_const(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
			6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
			6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
			6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
			6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
			6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
			6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
			6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
			6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
			6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
			6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
			6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
			6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
			6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
			6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
			6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
			6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
			6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
			6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
			6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
			6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
			6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
			6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
			6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
			6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
			6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
			6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
			6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
			6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
			6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
			6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
			6'd62: k = 32'h2AD7D2BB;  6'd63: k = 32'hEB86D391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [3:0] sel);
		logic [4:0] s;
		case (sel)
			4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
			4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] msg_index(input logic [5:0] i);
		logic [3:0] l;
		logic [3:0] g;
		l = i[3:0];
		case (i[5:4])
			2'd0:    g = l;
			2'd1:    g = 4'(l * 4'd5 + 4'd1);
			2'd2:    g = 4'(l * 4'd3 + 4'd5);
			default: g = 4'(l * 4'd7);
		endcase
		return g;
	endfunction

	function automatic logic [31:0] round_f(input logic [1:0] rnd, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		case (rnd)
			2'd0:    f = (b & c) | (~b & d);
			2'd1:    f = (d & b) | (~d & c);
			2'd2:    f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		return f;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
		logic [63:0] dbl;
		dbl = {x, x} << s;
		return dbl[63:32];
	endfunction

endpackage

`default_nettype wire

### src/md5_digest_engine_unit.sv
// ----------------------------------------------------------------------------
// MD5 digest engine
// Byte-serial MD5 with a microcoded sequencer over a single round datapath.
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle while a block fills. The beat that
// completes a 64-byte block starts a compression (load, 64 MD5 steps, each
// a round-add step and a rotate step, chaining add) followed by a return
// step, during which no beat is taken. A finishing beat runs the padding
// program: one byte of zero fill per cycle up to byte 56 (or to the block
// end and again from byte 0 when fewer than 8 bytes remain), the two length
// words, one or two compressions, then the four digest beats on the output,
// after which the next message may start.
`timescale 1ns / 1ps
`default_nettype none
`include "md5_digest_engine_unit_assert.svh"

module md5_digest_engine_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic [0:0]  s_tuser,   // [0] has_byte
	input  wire logic        s_tlast,   // finish
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] digest_word
	output logic [1:0]       m_tuser,   // [1:0] word_index
	output logic             m_tlast    // last_word
);
	import md5de_pkg::*;

	pc_t         pc_q;
	pc_t         pc_next;
	pc_t         ret_q;
	ucw_t        ucw;
	logic        cond_true;
	logic [31:0] chain_q [4];
	logic [60:0] count_q;
	logic        fin_q;
	logic [6:0]  ptr_q;
	logic [5:0]  cnt_q;
	logic [1:0]  emit_idx_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] t_q;
	logic [31:0] rd_q;
	logic [3:0][7:0] store_mem [16];
	logic [3:0]  mem_we;
	logic [3:0]  mem_waddr;
	logic [31:0] mem_wdata;
	logic [3:0]  mem_raddr;
	logic        in_beat;
	logic        out_beat;
	logic        start_cmp;
	logic [31:0] f_val;

	assign ucw       = ucode(pc_q);
	assign s_tready  = (ucw.op == OP_ACCEPT);
	assign m_tvalid  = (ucw.op == OP_EMIT);
	assign m_tdata   = chain_q[emit_idx_q];
	assign m_tuser   = emit_idx_q;
	assign m_tlast   = (emit_idx_q == 2'd3);
	assign in_beat   = s_tvalid && s_tready;
	assign out_beat  = m_tvalid && m_tready;
	assign start_cmp = in_beat && s_tuser[0] && (count_q[5:0] == 6'd63);
	assign f_val     = round_f(cnt_q[5:4], b_q, c_q, d_q);

	always_comb begin
		case (ucw.cond)
			C_ALWAYS:   cond_true = 1'b1;
			C_NOTFIN:   cond_true = !fin_q;
			C_NOTEXTRA: cond_true = (count_q[5:3] != 3'b111);
			C_PTR64:    cond_true = ptr_q[6];
			C_PTR56:    cond_true = (ptr_q == 7'd56);
			C_NOTDONE:  cond_true = (cnt_q != 6'd63);
			C_LASTBEAT: cond_true = out_beat && (emit_idx_q == 2'd3);
			default:    cond_true = 1'b0;
		endcase
	end

	always_comb begin
		pc_next = pc_q;
		case (ucw.jmp)
			J_NEXT:   pc_next = pc_q + 4'd1;
			J_CALL:   pc_next = ucw.target;
			J_RET:    pc_next = ret_q;
			J_IF:     pc_next = cond_true ? ucw.target : pc_q + 4'd1;
			J_WAIT:   pc_next = cond_true ? ucw.target : pc_q;
			J_ACCEPT: begin
				if (start_cmp) begin
					pc_next = ucw.target;
				end else if (in_beat && s_tlast) begin
					pc_next = PC_PAD;
				end
			end
			default:  pc_next = PC_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 4'b0000;
		mem_waddr = count_q[5:2];
		mem_wdata = {4{s_tdata}};
		mem_raddr = 4'd0;
		case (ucw.op)
			OP_ACCEPT: begin
				if (in_beat && s_tuser[0]) begin
					mem_we = 4'b0001 << count_q[1:0];
				end
			end
			OP_PAD80: begin
				mem_we    = 4'b0001 << count_q[1:0];
				mem_wdata = {4{PAD_BYTE}};
			end
			OP_ZERO: begin
				mem_waddr = ptr_q[5:2];
				mem_wdata = 32'h0;
				if (!cond_true) begin
					mem_we = 4'b0001 << ptr_q[1:0];
				end
			end
			OP_LENLO: begin
				mem_we    = 4'b1111;
				mem_waddr = LEN_LO_WORD;
				mem_wdata = {count_q[28:0], 3'b000};
			end
			OP_LENHI: begin
				mem_we    = 4'b1111;
				mem_waddr = LEN_HI_WORD;
				mem_wdata = count_q[60:29];
			end
			OP_LOAD: mem_raddr = msg_index(6'd0);
			OP_RB:   mem_raddr = msg_index(cnt_q + 6'd1);
			default: mem_raddr = 4'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 4; l++) begin
			if (mem_we[l]) begin
				store_mem[mem_waddr][l] <= mem_wdata[8*l +: 8];
			end
		end
		rd_q <= store_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q      <= PC_IDLE;
			chain_q[0] <= INIT_A;
			chain_q[1] <= INIT_B;
			chain_q[2] <= INIT_C;
			chain_q[3] <= INIT_D;
			count_q    <= '0;
			fin_q      <= 1'b0;
			ptr_q      <= '0;
			cnt_q      <= '0;
			emit_idx_q <= '0;
		end else begin
			if (ucw.jmp == J_CALL || (ucw.jmp == J_ACCEPT && start_cmp)) begin
				ret_q <= pc_q + 4'd1;
			end
			case (ucw.op)
				OP_ACCEPT: begin
					if (in_beat) begin
						fin_q <= s_tlast;
						if (s_tuser[0]) begin
							count_q <= count_q + 61'd1;
						end
					end
				end
				OP_PAD80:  ptr_q <= {1'b0, count_q[5:0]} + 7'd1;
				OP_ZERO: begin
					if (!cond_true) begin
						ptr_q <= ptr_q + 7'd1;
					end
				end
				OP_CLRPTR: ptr_q <= '0;
				OP_LOAD:   cnt_q <= '0;
				OP_RB:     cnt_q <= cnt_q + 6'd1;
				OP_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
				end
				OP_EMIT: begin
					if (out_beat) begin
						emit_idx_q <= emit_idx_q + 2'd1;
						if (emit_idx_q == 2'd3) begin
							chain_q[0] <= INIT_A;
							chain_q[1] <= INIT_B;
							chain_q[2] <= INIT_C;
							chain_q[3] <= INIT_D;
							count_q    <= '0;
							fin_q      <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ucw.op)
			OP_LOAD: begin
				a_q <= chain_q[0];
				b_q <= chain_q[1];
				c_q <= chain_q[2];
				d_q <= chain_q[3];
			end
			OP_RA:   t_q <= a_q + f_val + round_const(cnt_q) + rd_q;
			OP_RB: begin
				a_q <= d_q;
				d_q <= c_q;
				c_q <= b_q;
				b_q <= b_q + rotl32(t_q, rot_amount({cnt_q[5:4], cnt_q[1:0]}));
			end
			default: begin
			end
		endcase
	end

	`MDE_ASSERT_SAME(a_no_overlap, s_tready, !m_tvalid, "input and output both open")
	`MDE_ASSERT_NEXT(a_rounds_end, (pc_q == PC_RB) && (cnt_q == 6'd63), pc_q == PC_ADD, "round loop overran")
	`MDE_ASSERT_NEXT(a_idle_after_digest, out_beat && m_tlast, s_tready && (count_q == 61'd0), "no return to idle after digest")
	`MDE_ASSERT_NEXT(a_digest_held, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "digest word changed while stalled")
	`MDE_ASSERT_SAME(a_ptr_range, (pc_q == PC_ZERO56), !ptr_q[6] && (ptr_q <= 7'd56), "zero fill pointer out of range")

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// MD5 digest engine testbench
// Streams messages of mixed lengths byte by byte into the engine and checks
// every digest beat against a digest computed alongside. Both sides of the
// stream stall at random, and one long output stall backs up the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int ITEM_TARGET  = 370;
	localparam int RX_HOLD      = 3000;
	localparam int DRAIN_CYCLES = 400;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int DIGEST_WORDS = 4;

	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  word_sel;
		logic        last;
	} digest_beat_t;

	class md5_tracker;
		logic [31:0]  chain [4];
		logic [31:0]  blk [16];
		logic [31:0]  sine_k [64];
		logic [60:0]  count;
		digest_beat_t digest_words_due [$];
		int           failures;

		function new();
			int i;
			real r;
			logic [63:0] whole;
			for (i = 0; i < 64; i++) begin
				r = $sin(i + 1);
				if (r < 0.0)
					r = -r;
				whole = $floor(r * 4294967296.0);
				sine_k[i] = whole[31:0];
			end
			for (i = 0; i < 16; i++)
				blk[i] = '0;
			restore_chain();
			count = '0;
			failures = 0;
		endfunction

		function void restore_chain();
			chain[0] = md5de_pkg::INIT_A;
			chain[1] = md5de_pkg::INIT_B;
			chain[2] = md5de_pkg::INIT_C;
			chain[3] = md5de_pkg::INIT_D;
		endfunction

		function int shift_of(int step);
			case ((step / 16) * 4 + step % 4)
				0: return 7;   1: return 12;  2: return 17;  3: return 22;
				4: return 5;   5: return 9;   6: return 14;  7: return 20;
				8: return 4;   9: return 11;  10: return 16; 11: return 23;
				12: return 6;  13: return 10; 14: return 15; default: return 21;
			endcase
		endfunction

		function void md5_compress();
			logic [31:0] a, b, c, d, f, t, sum;
			int i, g, s;
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			for (i = 0; i < 64; i++) begin
				case (i / 16)
					0: begin
						f = (b & c) | (~b & d);
						g = i;
					end
					1: begin
						f = (d & b) | (~d & c);
						g = (5 * i + 1) % 16;
					end
					2: begin
						f = b ^ c ^ d;
						g = (3 * i + 5) % 16;
					end
					default: begin
						f = c ^ (b | ~d);
						g = (7 * i) % 16;
					end
				endcase
				sum = a + f + sine_k[i] + blk[g];
				s = shift_of(i);
				t = d;
				d = c;
				c = b;
				b = b + ((sum << s) | (sum >> (32 - s)));
				a = t;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
		endfunction

		function void put_byte(int pos, logic [7:0] value);
			blk[pos / 4][(pos % 4) * 8 +: 8] = value;
		endfunction

		function void take_beat(logic [7:0] data, logic has, logic fin);
			int pos, used, k;
			logic [63:0] bit_len;
			digest_beat_t beat;
			if (has) begin
				pos = int'(count[5:0]);
				put_byte(pos, data);
				count = count + 1'b1;
				if (pos == 63)
					md5_compress();
			end
			if (!fin)
				return;
			used = int'(count[5:0]);
			put_byte(used, md5de_pkg::PAD_BYTE);
			used++;
			if (64 - used < 8) begin
				for (pos = used; pos < 64; pos++)
					put_byte(pos, 8'h00);
				md5_compress();
				used = 0;
			end
			for (pos = used; pos < 56; pos++)
				put_byte(pos, 8'h00);
			bit_len = {count, 3'b000};
			blk[14] = bit_len[31:0];
			blk[15] = bit_len[63:32];
			md5_compress();
			for (k = 0; k < DIGEST_WORDS; k++) begin
				beat.word = chain[k];
				beat.word_sel = 2'(k);
				beat.last = (k == DIGEST_WORDS - 1);
				digest_words_due.push_back(beat);
			end
			restore_chain();
			count = '0;
		endfunction

		function void flag_failure(string msg);
			failures++;
			if (failures <= 10)
				$display("%s", msg);
		endfunction

		function void match_digest_word(logic [31:0] word, logic [1:0] word_sel, logic last);
			digest_beat_t due;
			if (digest_words_due.size() == 0) begin
				flag_failure($sformatf("%0t: unexpected digest beat word %h index %0d last %0b",
					$time, word, word_sel, last));
				return;
			end
			due = digest_words_due.pop_front();
			if (word !== due.word || word_sel !== due.word_sel || last !== due.last)
				flag_failure($sformatf(
					"%0t: digest beat mismatch: expected word %h index %0d last %0b, got %h %0d %0b",
					$time, due.word, due.word_sel, due.last, word, word_sel, last));
		endfunction

		function int pending();
			return digest_words_due.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	md5_tracker tracker;
	int         items_sent = 0;
	int         tx_mode = 0;
	int         rx_mode = 0;
	bit         long_hold_pending = 1'b0;

	md5_digest_engine_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int draw_gap(int mode);
		case (mode)
			0: return 0;
			1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
			default: return $urandom_range(0, 14);
		endcase
	endfunction

	task automatic send_beat(input logic [7:0] data, input logic has, input logic fin);
		int gap;
		gap = draw_gap(tx_mode);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= has;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		tracker.take_beat(data, has, fin);
		items_sent++;
	endtask

	task automatic send_message(input int len, input bit fin_with_byte);
		int i;
		bit fin;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			fin = (i == len - 1) && fin_with_byte;
			send_beat(8'($urandom_range(0, 255)), 1'b1, fin);
		end
		if (len == 0 || !fin_with_byte)
			send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = long_hold_pending ? RX_HOLD : draw_gap(rx_mode);
			long_hold_pending = 1'b0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			tracker.match_digest_word(m_tdata, m_tuser, m_tlast);
			if ($urandom_range(0, 7) == 0)
				rx_mode = $urandom_range(0, 2);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		int len, pick;
		tracker = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(8'hFF, 1'b0, 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'h00, 1'b1, 1'b1);
		send_beat(8'hFF, 1'b1, 1'b1);
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h5A, 1'b0, 1'b0);
		send_beat(8'h63, 1'b1, 1'b1);
		send_beat(8'hFF, 1'b1, 1'b0);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'hFF, 1'b0, 1'b1);

		long_hold_pending = 1'b1;
		while (items_sent < ITEM_TARGET) begin
			tx_mode = $urandom_range(0, 2);
			pick = $urandom_range(0, 99);
			if (pick < 70)
				len = $urandom_range(0, 12);
			else if (pick < 92)
				len = $urandom_range(52, 72);
			else
				len = $urandom_range(100, 130);
			if (len > ITEM_TARGET - items_sent)
				len = ITEM_TARGET - items_sent;
			send_message(len, 1'($urandom_range(0, 1)));
		end
		s_tvalid <= 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
